### hw/rtl/cda_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Calendar date arithmetic package
// Shared widths, constants, microcode types and calendar helper functions.
// ----------------------------------------------------------------------------
package cda_pkg;

   localparam int MAX_YEAR   = 9999;
   localparam int YEAR_W     = 14;
   localparam int MONTH_W    = 4;
   localparam int DAY_W      = 5;
   localparam int CNT_W      = 23;
   localparam int SER_W      = 23;
   localparam int SUM_W      = 25;
   localparam int DIFF_W     = 24;
   localparam int MUL_A_W    = 23;
   localparam int MUL_B_W    = 13;
   localparam int PROD_W     = MUL_A_W + MUL_B_W;
   localparam int YDAY_W     = 9;
   localparam int STEP_W     = 5;
   localparam int CNT_LIMIT  = 4194303;
   localparam int TOP_SERIAL = (MAX_YEAR + 1) * 365 + (MAX_YEAR + 4) / 4
                               - (MAX_YEAR + 100) / 100 + (MAX_YEAR + 400) / 400 - 1;

   localparam logic [MUL_B_W-1:0] RECIP_100   = 13'd5243;
   localparam int                 RECIP_SHIFT = 19;
   localparam logic [MUL_B_W-1:0] RECIP_YEAR  = 13'd2871;
   localparam int                 YEAR_SHIFT  = 20;

   typedef enum logic [3:0] {
      OP_LEAP_MUL,
      OP_LEAP_SET,
      OP_DBY1,
      OP_DBY2,
      OP_DBY3,
      OP_SER_A,
      OP_SER_B,
      OP_SHIFT,
      OP_EST_MUL,
      OP_EST_SET,
      OP_CHK_DOWN,
      OP_CHK_UP,
      OP_MONTH,
      OP_FIN_S,
      OP_FIN_D
   } uop_type;

   typedef enum logic [1:0] {
      YS_A,
      YS_B,
      YS_Y,
      YS_Y1
   } ysel_type;

   typedef enum logic [2:0] {
      C_NEXT,
      C_DIFF,
      C_BAD,
      C_GT,
      C_LE,
      C_DONE
   } cond_type;

   typedef struct packed {
      uop_type                op;
      ysel_type               ysel;
      cond_type               cond;
      logic [STEP_W-1:0]      target;
   } cw_type;

   typedef struct packed {
      logic is_diff;
      logic a_bad;
      logic q_gt_s;
      logic out_free;
   } stat_type;

   function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
      logic [DAY_W-1:0] n;
      begin
         case (m)
            4'd2: begin
               n = leap ? 5'd29 : 5'd28;
            end
            4'd4, 4'd6, 4'd9, 4'd11: begin
               n = 5'd30;
            end
            default: begin
               n = 5'd31;
            end
         endcase
         return n;
      end
   endfunction

   function automatic logic [YDAY_W-1:0] cum_days(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
      logic [YDAY_W-1:0] base;
      begin
         case (m)
            4'd2:    base = 9'd31;
            4'd3:    base = 9'd59;
            4'd4:    base = 9'd90;
            4'd5:    base = 9'd120;
            4'd6:    base = 9'd151;
            4'd7:    base = 9'd181;
            4'd8:    base = 9'd212;
            4'd9:    base = 9'd243;
            4'd10:   base = 9'd273;
            4'd11:   base = 9'd304;
            4'd12:   base = 9'd334;
            default: base = 9'd0;
         endcase
         return base + YDAY_W'(leap && (m > 4'd2) && (m <= 4'd12));
      end
   endfunction

   function automatic logic date_ok(input logic [YEAR_W-1:0] y,
                                    input logic [MONTH_W-1:0] m,
                                    input logic [DAY_W-1:0] d,
                                    input logic leap);
      begin
         return (y <= YEAR_W'(MAX_YEAR)) && (m >= 4'd1) && (m <= 4'd12)
                && (d >= 5'd1) && (d <= month_len(m, leap));
      end
   endfunction

endpackage

### hw/rtl/calendar_date_arithmetic.sv
`timescale 1ns / 1ps
// Difference items and shift items take separate microcode paths; a legal shift
// adds a year search that steps the year estimate, while an illegal one skips it.
// The microcode sequencer and its one shared multiplier carry out these steps.
// One item is in work at a time; the next is taken once the result is registered.
// Reset (synchronous, active high) idles the sequencer and empties the result.
// ----------------------------------------------------------------------------
// Calendar date arithmetic
// Gregorian date shift by a signed day count, and day difference of two dates.
// ----------------------------------------------------------------------------
module calendar_date_arithmetic (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_action,
   input  logic [cda_pkg::YEAR_W-1:0]         req_year_a,
   input  logic [cda_pkg::MONTH_W-1:0]        req_month_a,
   input  logic [cda_pkg::DAY_W-1:0]          req_day_a,
   input  logic [cda_pkg::YEAR_W-1:0]         req_year_b,
   input  logic [cda_pkg::MONTH_W-1:0]        req_month_b,
   input  logic [cda_pkg::DAY_W-1:0]          req_day_b,
   input  logic signed [cda_pkg::CNT_W-1:0]   req_day_offset,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [cda_pkg::YEAR_W-1:0]         rsp_res_year,
   output logic [cda_pkg::MONTH_W-1:0]        rsp_res_month,
   output logic [cda_pkg::DAY_W-1:0]          rsp_res_day,
   output logic signed [cda_pkg::CNT_W-1:0]   rsp_day_count,
   output logic                               rsp_a_less,
   output logic                               rsp_a_equal,
   output logic                               rsp_input_valid,
   output logic                               rsp_overflow
);
   import cda_pkg::*;

   cw_type                   cw;
   stat_type                 stat;
   logic                     busy;
   logic                     accept;
   logic                     fin;

   logic                     action_ff;
   logic [YEAR_W-1:0]        ya_ff, yb_ff;
   logic [MONTH_W-1:0]       ma_ff, mb_ff;
   logic [DAY_W-1:0]         da_ff, db_ff;
   logic signed [CNT_W-1:0]  off_ff;

   logic [PROD_W-1:0]        prod_ff, prod_in;
   logic [SER_W-1:0]         q_ff, q_in;
   logic [SER_W-1:0]         sa_ff, sa_in;
   logic [SER_W-1:0]         sb_ff, sb_in;
   logic [SER_W-1:0]         s_ff, s_in;
   logic [SER_W-1:0]         d_ff, d_in;
   logic                     ovf_ff, ovf_in;
   logic [YEAR_W-1:0]        yy_ff, yy_in;
   logic [MONTH_W-1:0]       mm_ff, mm_in;
   logic [DAY_W-1:0]         dd_ff, dd_in;
   logic                     leap_a_ff, leap_a_in;
   logic                     leap_b_ff, leap_b_in;
   logic                     leap_y_ff, leap_y_in;

   logic                     rsp_valid_ff;
   logic [YEAR_W-1:0]        res_year_ff, res_year_in;
   logic [MONTH_W-1:0]       res_month_ff, res_month_in;
   logic [DAY_W-1:0]         res_day_ff, res_day_in;
   logic signed [CNT_W-1:0]  count_ff, count_in;
   logic                     less_ff, less_in;
   logic                     equal_ff, equal_in;
   logic                     ivalid_ff, ivalid_in;
   logic                     ovf_out_ff, ovf_out_in;

   logic [YEAR_W-1:0]        y_sel;
   logic [SER_W-1:0]         y_ext;
   logic [MUL_A_W-1:0]       mul_a;
   logic [MUL_B_W-1:0]       mul_b;
   logic [YEAR_W-1:0]        q100;
   logic                     div100;
   logic                     leap_new;
   logic signed [SUM_W-1:0]  sum;
   logic [SER_W-1:0]         prod_q;
   logic [YDAY_W-1:0]        rem;
   logic [YDAY_W-1:0]        base;
   logic [YDAY_W-1:0]        cum;
   logic                     a_ok, b_ok;
   logic signed [DIFF_W-1:0] diff;

   assign accept    = req_valid && !req_stall;
   assign req_stall = busy;
   assign fin       = busy && stat.out_free
                      && (cw.op == OP_FIN_S || cw.op == OP_FIN_D);

   assign a_ok = date_ok(ya_ff, ma_ff, da_ff, leap_a_ff);
   assign b_ok = date_ok(yb_ff, mb_ff, db_ff, leap_b_ff);

   assign stat.is_diff  = action_ff;
   assign stat.a_bad    = !a_ok;
   assign stat.q_gt_s   = q_ff > s_ff;
   assign stat.out_free = !rsp_valid_ff || !rsp_stall;

   cda_seq u_seq (
      .clock (clock),
      .reset (reset),
      .start (accept),
      .stat  (stat),
      .cw    (cw),
      .busy  (busy)
   );

   always_comb begin
      case (cw.ysel)
         YS_A:    y_sel = ya_ff;
         YS_B:    y_sel = yb_ff;
         YS_Y1:   y_sel = yy_ff + 14'd1;
         default: y_sel = yy_ff;
      endcase
      y_ext = SER_W'(y_sel);

      case (cw.op)
         OP_DBY1: begin
            mul_a = MUL_A_W'(y_ext + 23'd99);
            mul_b = RECIP_100;
         end
         OP_DBY2: begin
            mul_a = MUL_A_W'((y_ext + 23'd399) >> 2);
            mul_b = RECIP_100;
         end
         OP_EST_MUL: begin
            mul_a = MUL_A_W'(s_ff);
            mul_b = RECIP_YEAR;
         end
         default: begin
            mul_a = MUL_A_W'(y_ext);
            mul_b = RECIP_100;
         end
      endcase
      prod_in = PROD_W'(mul_a) * PROD_W'(mul_b);
   end

   always_comb begin
      q100     = prod_ff[RECIP_SHIFT +: YEAR_W];
      div100   = (YEAR_W'(q100 * 14'd100) == y_sel);
      leap_new = (y_sel[1:0] == 2'b00) && (!div100 || (q100[1:0] == 2'b00));
      prod_q   = SER_W'(prod_ff >> RECIP_SHIFT);
      sum      = $signed({2'b00, sa_ff}) + SUM_W'(off_ff);
      rem      = YDAY_W'(s_ff - d_ff);
      base     = '0;
      mm_in    = mm_ff;
      for (int m = 1; m <= 12; m++) begin
         cum = cum_days(MONTH_W'(m), leap_y_ff);
         if (cum <= rem) begin
            mm_in = MONTH_W'(m);
            base  = cum;
         end
      end
      diff = $signed({1'b0, sb_ff}) - $signed({1'b0, sa_ff});

      q_in      = q_ff;
      sa_in     = sa_ff;
      sb_in     = sb_ff;
      s_in      = s_ff;
      d_in      = d_ff;
      ovf_in    = ovf_ff;
      yy_in     = yy_ff;
      dd_in     = dd_ff;
      leap_a_in = leap_a_ff;
      leap_b_in = leap_b_ff;
      leap_y_in = leap_y_ff;

      case (cw.op)
         OP_LEAP_SET: begin
            case (cw.ysel)
               YS_A:    leap_a_in = leap_new;
               YS_B:    leap_b_in = leap_new;
               default: leap_y_in = leap_new;
            endcase
         end
         OP_DBY1: begin
            q_in = y_ext * 23'd365 + ((y_ext + 23'd3) >> 2);
         end
         OP_DBY2: begin
            q_in = q_ff - prod_q;
         end
         OP_DBY3: begin
            q_in = q_ff + prod_q;
         end
         OP_SER_A: begin
            sa_in = q_ff + SER_W'(cum_days(ma_ff, leap_a_ff)) + SER_W'(da_ff) - 23'd1;
         end
         OP_SER_B: begin
            sb_in = q_ff + SER_W'(cum_days(mb_ff, leap_b_ff)) + SER_W'(db_ff) - 23'd1;
         end
         OP_SHIFT: begin
            if (sum < 0) begin
               s_in   = '0;
               ovf_in = 1'b1;
            end else if (sum > $signed(SUM_W'(TOP_SERIAL))) begin
               s_in   = SER_W'(TOP_SERIAL);
               ovf_in = 1'b1;
            end else begin
               s_in   = sum[SER_W-1:0];
               ovf_in = 1'b0;
            end
         end
         OP_EST_SET: begin
            yy_in = prod_ff[YEAR_SHIFT +: YEAR_W];
         end
         OP_CHK_DOWN: begin
            if (stat.q_gt_s) begin
               yy_in = yy_ff - 14'd1;
            end else begin
               d_in = q_ff;
            end
         end
         OP_CHK_UP: begin
            if (!stat.q_gt_s) begin
               yy_in = yy_ff + 14'd1;
               d_in  = q_ff;
            end
         end
         OP_MONTH: begin
            dd_in = DAY_W'(rem - base + 9'd1);
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      res_year_in  = '0;
      res_month_in = '0;
      res_day_in   = '0;
      count_in     = '0;
      less_in      = 1'b0;
      equal_in     = 1'b0;
      ivalid_in    = 1'b0;
      ovf_out_in   = 1'b0;
      if (cw.op == OP_FIN_S) begin
         if (a_ok) begin
            res_year_in  = yy_ff;
            res_month_in = mm_ff;
            res_day_in   = dd_ff;
            ivalid_in    = 1'b1;
            ovf_out_in   = ovf_ff;
         end else begin
            res_year_in  = ya_ff;
            res_month_in = ma_ff;
            res_day_in   = da_ff;
         end
      end else begin
         less_in  = (ya_ff < yb_ff)
                    || (ya_ff == yb_ff && (ma_ff < mb_ff || (ma_ff == mb_ff && da_ff < db_ff)));
         equal_in = (ya_ff == yb_ff) && (ma_ff == mb_ff) && (da_ff == db_ff);
         if (a_ok && b_ok) begin
            ivalid_in = 1'b1;
            if (diff > $signed(DIFF_W'(CNT_LIMIT))) begin
               count_in   = CNT_W'(CNT_LIMIT);
               ovf_out_in = 1'b1;
            end else if (diff < -$signed(DIFF_W'(CNT_LIMIT))) begin
               count_in   = -CNT_W'(CNT_LIMIT);
               ovf_out_in = 1'b1;
            end else begin
               count_in   = diff[CNT_W-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         action_ff <= req_action;
         ya_ff     <= req_year_a;
         ma_ff     <= req_month_a;
         da_ff     <= req_day_a;
         yb_ff     <= req_year_b;
         mb_ff     <= req_month_b;
         db_ff     <= req_day_b;
         off_ff    <= req_day_offset;
      end
      prod_ff   <= prod_in;
      q_ff      <= q_in;
      sa_ff     <= sa_in;
      sb_ff     <= sb_in;
      s_ff      <= s_in;
      d_ff      <= d_in;
      ovf_ff    <= ovf_in;
      mm_ff     <= (cw.op == OP_MONTH) ? mm_in : mm_ff;
      dd_ff     <= dd_in;
      leap_a_ff <= leap_a_in;
      leap_b_ff <= leap_b_in;
      leap_y_ff <= leap_y_in;
      if (fin) begin
         res_year_ff  <= res_year_in;
         res_month_ff <= res_month_in;
         res_day_ff   <= res_day_in;
         count_ff     <= count_in;
         less_ff      <= less_in;
         equal_ff     <= equal_in;
         ivalid_ff    <= ivalid_in;
         ovf_out_ff   <= ovf_out_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         yy_ff        <= '0;
      end else begin
         yy_ff <= yy_in;
         if (fin) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_res_year    = res_year_ff;
   assign rsp_res_month   = res_month_ff;
   assign rsp_res_day     = res_day_ff;
   assign rsp_day_count   = count_ff;
   assign rsp_a_less      = less_ff;
   assign rsp_a_equal     = equal_ff;
   assign rsp_input_valid = ivalid_ff;
   assign rsp_overflow    = ovf_out_ff;

   a_shift_date_legal: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_input_valid && rsp_res_month != 4'd0)
      |-> (rsp_res_month <= 4'd12 && rsp_res_day != 5'd0
           && rsp_res_year <= YEAR_W'(MAX_YEAR)))
      else $error("shifted date is not a legal date");

   a_less_equal_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_a_less && rsp_a_equal))
      else $error("less and equal flags both set");

   a_overflow_valid: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_overflow) |-> rsp_input_valid)
      else $error("overflow reported for illegal input");

   a_year_search_range: assert property (@(posedge clock) disable iff (reset)
      busy |-> (yy_ff <= YEAR_W'(MAX_YEAR + 1)))
      else $error("year search left the year range");

endmodule

### hw/rtl/cda_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Calendar date arithmetic sequencer
// Step counter and microcode table: one datapath step a cycle save on rsp stall.
// ----------------------------------------------------------------------------
module cda_seq (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  cda_pkg::stat_type  stat,
   output cda_pkg::cw_type    cw,
   output logic               busy
);
   import cda_pkg::*;

   typedef enum logic {
      SEQ_IDLE,
      SEQ_RUN
   } seq_state_type;

   localparam logic [STEP_W-1:0] L_YDOWN = 5'd9;
   localparam logic [STEP_W-1:0] L_YUP   = 5'd13;
   localparam logic [STEP_W-1:0] L_FIN_S = 5'd20;
   localparam logic [STEP_W-1:0] L_DIFF  = 5'd21;

   seq_state_type     state_ff;
   logic [STEP_W-1:0] step_ff;
   logic [STEP_W-1:0] step_in;
   logic              take;

   function automatic cw_type mk(input uop_type op, input ysel_type ys,
                                 input cond_type c, input logic [STEP_W-1:0] t);
      cw_type w;
      begin
         w.op     = op;
         w.ysel   = ys;
         w.cond   = c;
         w.target = t;
         return w;
      end
   endfunction

   function automatic cw_type ucode(input logic [STEP_W-1:0] addr);
      cw_type w;
      begin
         case (addr)
            5'd0:    w = mk(OP_LEAP_MUL, YS_A,  C_NEXT, '0);
            5'd1:    w = mk(OP_LEAP_SET, YS_A,  C_NEXT, '0);
            5'd2:    w = mk(OP_DBY1,     YS_A,  C_NEXT, '0);
            5'd3:    w = mk(OP_DBY2,     YS_A,  C_NEXT, '0);
            5'd4:    w = mk(OP_DBY3,     YS_A,  C_NEXT, '0);
            5'd5:    w = mk(OP_SER_A,    YS_A,  C_DIFF, L_DIFF);
            5'd6:    w = mk(OP_SHIFT,    YS_A,  C_BAD,  L_FIN_S);
            5'd7:    w = mk(OP_EST_MUL,  YS_Y,  C_NEXT, '0);
            5'd8:    w = mk(OP_EST_SET,  YS_Y,  C_NEXT, '0);
            5'd9:    w = mk(OP_DBY1,     YS_Y,  C_NEXT, '0);
            5'd10:   w = mk(OP_DBY2,     YS_Y,  C_NEXT, '0);
            5'd11:   w = mk(OP_DBY3,     YS_Y,  C_NEXT, '0);
            5'd12:   w = mk(OP_CHK_DOWN, YS_Y,  C_GT,   L_YDOWN);
            5'd13:   w = mk(OP_DBY1,     YS_Y1, C_NEXT, '0);
            5'd14:   w = mk(OP_DBY2,     YS_Y1, C_NEXT, '0);
            5'd15:   w = mk(OP_DBY3,     YS_Y1, C_NEXT, '0);
            5'd16:   w = mk(OP_CHK_UP,   YS_Y,  C_LE,   L_YUP);
            5'd17:   w = mk(OP_LEAP_MUL, YS_Y,  C_NEXT, '0);
            5'd18:   w = mk(OP_LEAP_SET, YS_Y,  C_NEXT, '0);
            5'd19:   w = mk(OP_MONTH,    YS_Y,  C_NEXT, '0);
            5'd20:   w = mk(OP_FIN_S,    YS_Y,  C_DONE, '0);
            5'd21:   w = mk(OP_LEAP_MUL, YS_B,  C_NEXT, '0);
            5'd22:   w = mk(OP_LEAP_SET, YS_B,  C_NEXT, '0);
            5'd23:   w = mk(OP_DBY1,     YS_B,  C_NEXT, '0);
            5'd24:   w = mk(OP_DBY2,     YS_B,  C_NEXT, '0);
            5'd25:   w = mk(OP_DBY3,     YS_B,  C_NEXT, '0);
            5'd26:   w = mk(OP_SER_B,    YS_B,  C_NEXT, '0);
            5'd27:   w = mk(OP_FIN_D,    YS_B,  C_DONE, '0);
            default: w = mk(OP_FIN_D,    YS_B,  C_DONE, '0);
         endcase
         return w;
      end
   endfunction

   assign cw   = ucode(step_ff);
   assign busy = (state_ff == SEQ_RUN);

   always_comb begin
      case (cw.cond)
         C_DIFF:  take = stat.is_diff;
         C_BAD:   take = stat.a_bad;
         C_GT:    take = stat.q_gt_s;
         C_LE:    take = !stat.q_gt_s;
         default: take = 1'b0;
      endcase
      step_in = take ? cw.target : step_ff + 5'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SEQ_IDLE;
         step_ff  <= '0;
      end else begin
         case (state_ff)
            SEQ_IDLE: begin
               if (start) begin
                  state_ff <= SEQ_RUN;
                  step_ff  <= '0;
               end
            end
            SEQ_RUN: begin
               if (cw.cond == C_DONE) begin
                  if (stat.out_free) begin
                     state_ff <= SEQ_IDLE;
                  end
               end else begin
                  step_ff <= step_in;
               end
            end
            default: begin
               state_ff <= SEQ_IDLE;
            end
         endcase
      end
   end

endmodule
